// ===== hdl/rfc_pkg.sv =====
// Shared constants, types and the CRC byte update for the RTU frame checker.
package rfc_pkg;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frames shorter than this are rejected
	localparam logic [2:0] MIN_FRAME = 3'd4;

	// Byte positions within the frame
	localparam logic [2:0] POS_ADDR     = 3'd0;
	localparam logic [2:0] POS_FUNC     = 3'd1;
	localparam logic [2:0] POS_START_HI = 3'd2;
	localparam logic [2:0] POS_START_LO = 3'd3;

	// Supported function codes
	localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
	localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
	localparam logic [7:0] FC_ENCAPSULATED  = 8'h2B;

	// Frame status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SHORT     = 2'd1;
	localparam logic [1:0] STATUS_CRC_FAULT = 2'd2;
	localparam logic [1:0] STATUS_BAD_FUNC  = 2'd3;

	// One checked frame
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  server_address;
		logic [7:0]  function_code;
		logic [15:0] start_register;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	// Reflected CRC update over one byte, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/rfc_in_if.sv =====
// Byte channel into the RTU frame checker.
interface rfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/rfc_out_if.sv =====
// Result channel out of the RTU frame checker.
interface rfc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  server_address;
	logic [7:0]  function_code;
	logic [15:0] start_register;
	logic [15:0] received_crc;
	logic [15:0] computed_crc;

	modport source (output valid, output status, output server_address, output function_code,
		output start_register, output received_crc, output computed_crc, input ready);
	modport sink (input valid, input status, input server_address, input function_code,
		input start_register, input received_crc, input computed_crc, output ready);
endinterface

// ===== hdl/rfc_frame_state.sv =====
// Per-frame state: CRC register, delay pair, byte counter, header holds and result logic.
module rfc_frame_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               res_valid,
	output rfc_pkg::result_t   res
);

	logic [15:0] crc_q;
	logic [7:0]  dly0_q;
	logic [7:0]  dly1_q;
	logic [2:0]  count_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [15:0] start_q;

	logic [15:0] crc_nxt;
	logic [2:0]  count_nxt;
	logic [7:0]  addr_nxt;
	logic [7:0]  func_nxt;
	logic [15:0] start_nxt;
	logic [15:0] rx_crc;
	logic [15:0] calc_crc;

	// Next state for this transaction
	always_comb begin
		crc_nxt   = (count_q >= 3'd2) ? rfc_pkg::crc_byte(crc_q, dly1_q) : crc_q;
		count_nxt = (count_q < rfc_pkg::MIN_FRAME) ? count_q + 3'd1 : count_q;
		addr_nxt  = addr_q;
		func_nxt  = func_q;
		start_nxt = start_q;
		case (count_q)
			rfc_pkg::POS_ADDR:     addr_nxt = data_byte;
			rfc_pkg::POS_FUNC:     func_nxt = data_byte;
			rfc_pkg::POS_START_HI: start_nxt = {data_byte, start_q[7:0]};
			rfc_pkg::POS_START_LO: start_nxt = {start_q[15:8], data_byte};
			default: ;
		endcase
	end

	// Result of a frame that ends on this byte
	always_comb begin
		rx_crc   = {dly0_q, data_byte};
		calc_crc = {crc_nxt[7:0], crc_nxt[15:8]};
		res      = '0;
		if (count_nxt < rfc_pkg::MIN_FRAME) begin
			res.status = rfc_pkg::STATUS_SHORT;
		end else begin
			if (calc_crc != rx_crc) begin
				res.status = rfc_pkg::STATUS_CRC_FAULT;
			end else if (func_nxt inside {rfc_pkg::FC_READ_HOLDING, rfc_pkg::FC_WRITE_SINGLE,
					rfc_pkg::FC_WRITE_MULTI, rfc_pkg::FC_ENCAPSULATED}) begin
				res.status = rfc_pkg::STATUS_OK;
			end else begin
				res.status = rfc_pkg::STATUS_BAD_FUNC;
			end
			res.server_address = addr_nxt;
			res.function_code  = func_nxt;
			res.start_register = start_nxt;
			res.received_crc   = rx_crc;
			res.computed_crc   = calc_crc;
		end
	end

	assign res_valid = accept & last_byte;

	// State registers; the last byte returns everything to the start of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= rfc_pkg::CRC_INIT;
			dly0_q  <= '0;
			dly1_q  <= '0;
			count_q <= '0;
			addr_q  <= '0;
			func_q  <= '0;
			start_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				crc_q   <= rfc_pkg::CRC_INIT;
				dly0_q  <= '0;
				dly1_q  <= '0;
				count_q <= '0;
				addr_q  <= '0;
				func_q  <= '0;
				start_q <= '0;
			end else begin
				crc_q   <= crc_nxt;
				dly0_q  <= data_byte;
				dly1_q  <= dly0_q;
				count_q <= count_nxt;
				addr_q  <= addr_nxt;
				func_q  <= func_nxt;
				start_q <= start_nxt;
			end
		end
	end

endmodule

// ===== hdl/rfc_out_reg.sv =====
// Result register with valid/ready hand-off.
module rfc_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rfc_pkg::result_t res,
	output logic             can_load,
	rfc_out_if.source        out_ch
);

	logic             valid_q;
	rfc_pkg::result_t res_q;

	// Space when empty or when the held result leaves this cycle
	assign can_load = ~valid_q | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.status         = res_q.status;
	assign out_ch.server_address = res_q.server_address;
	assign out_ch.function_code  = res_q.function_code;
	assign out_ch.start_register = res_q.start_register;
	assign out_ch.received_crc   = res_q.received_crc;
	assign out_ch.computed_crc   = res_q.computed_crc;

endmodule

// ===== hdl/rtu_frame_checker_top.sv =====
// Top level of the RTU frame checker.
//
//  channel  dir  payload                                           per transaction
//  frm      in   data_byte, last_byte                              one frame byte
//  rpt      out  status, server_address, function_code,            one checked frame
//                start_register, received_crc, computed_crc
//
// While frm.ready is high one byte is taken per cycle; the CRC byte update and the
// checks sit between the frame state registers and the result register. A frame's
// result appears on rpt the cycle after its last byte. Reset clears the frame state and
// the result valid. frm.ready drops only while a held result is not being taken on rpt.
module rtu_frame_checker_top (
	input  logic      clk,
	input  logic      arst_n,
	rfc_in_if.sink    frm,
	rfc_out_if.source rpt
);

	logic             accept;
	logic             can_load;
	logic             res_valid;
	rfc_pkg::result_t res;

	assign frm.ready = can_load;
	assign accept    = frm.valid & can_load;

	rfc_frame_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (frm.data_byte),
		.last_byte (frm.last_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	rfc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.can_load (can_load),
		.out_ch   (rpt)
	);

endmodule
